// ===== hdl/bmp_pkg.sv =====
// Shared constants and types for the binomial coefficient modulo prime block.
`default_nettype none
package bmp_pkg;

  // Width of a residue modulo the prime.
  localparam int unsigned VAL_W = 30;
  // Width of a full product of two residues.
  localparam int unsigned PROD_W = 2 * VAL_W;
  // Barrett reduction widths.
  localparam int unsigned MU_W = VAL_W + 1;
  localparam int unsigned T_W = 2 * MU_W;
  localparam int unsigned R_W = VAL_W + 2;
  // Number of exponent bits, one cell each.
  localparam int unsigned EXP_BITS = VAL_W;
  // Pipeline depth of one modular multiplier.
  localparam int unsigned MODMUL_STAGES = 4;

  localparam logic [VAL_W-1:0] PRIME_MOD = 30'd1000000007;
  localparam logic [VAL_W-1:0] FERMAT_EXP = PRIME_MOD - 30'd2;

  // Barrett constant floor(2^60 / p), computed at elaboration.
  localparam logic [63:0] MU_FULL = (64'd1 << PROD_W) / 64'(PRIME_MOD);
  localparam logic [MU_W-1:0] BARRETT_MU = MU_FULL[MU_W-1:0];

  localparam logic [R_W-1:0] PRIME_R = R_W'(PRIME_MOD);
  localparam logic [R_W-1:0] PRIME_R2 = R_W'(PRIME_MOD) << 1;

  // Side information that travels with each item down the pipeline.
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [VAL_W-1:0] numer;
  } bmp_tag_t;

endpackage
`default_nettype wire

// ===== hdl/bmp_rom.sv =====
// Read-only factorial table with a registered read port.
`default_nettype none
module bmp_rom #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [$clog2(DEPTH)-1:0]      addr_i,
  output logic      [bmp_pkg::VAL_W-1:0]     data_o
);
  import bmp_pkg::*;

  typedef logic [VAL_W-1:0] rom_arr_t [DEPTH];

  // Entry i holds i! modulo the prime.
  function automatic rom_arr_t build_table();
    rom_arr_t    tab;
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < DEPTH; i++) begin
      tab[i] = acc[VAL_W-1:0];
      acc = (acc * 64'(i + 1)) % 64'(PRIME_MOD);
    end
    return tab;
  endfunction

  localparam rom_arr_t ROM_DATA = build_table();

  logic [VAL_W-1:0] data_q;

  // The read data is registered and holds while the pipeline stalls.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM_DATA[addr_i];
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== hdl/bmp_modmul.sv =====
// Four-stage modular multiplier with Barrett reduction and a travelling tag.
`default_nettype none
module bmp_modmul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic     [bmp_pkg::VAL_W-1:0] a_i,
  input  wire logic     [bmp_pkg::VAL_W-1:0] b_i,
  input  wire bmp_pkg::bmp_tag_t             tag_i,
  output logic          [bmp_pkg::VAL_W-1:0] prod_o,
  output bmp_pkg::bmp_tag_t                  tag_o
);
  import bmp_pkg::*;

  logic [PROD_W-1:0] prod1_q;
  logic [R_W-1:0]    xlo2_q;
  logic [T_W-1:0]    t2_q;
  logic [R_W-1:0]    r3_q;
  logic [VAL_W-1:0]  res4_q;
  bmp_tag_t          tag_q [MODMUL_STAGES];

  logic [PROD_W-1:0] prod1_d;
  logic [T_W-1:0]    t2_d;
  logic [MU_W-1:0]   q3;
  logic [R_W-1:0]    qp3;
  logic [R_W-1:0]    r3_d;
  logic [VAL_W-1:0]  res4_d;

  // Stage one forms the full product.
  assign prod1_d = PROD_W'(a_i) * PROD_W'(b_i);

  // Stage two estimates the quotient from the upper product bits.
  assign t2_d = T_W'(prod1_q[PROD_W-1:VAL_W-1]) * T_W'(BARRETT_MU);

  // Stage three subtracts quotient times prime; the remainder is below 3p.
  assign q3   = t2_q[T_W-1:MU_W];
  assign qp3  = R_W'(R_W'(q3) * PRIME_R);
  assign r3_d = xlo2_q - qp3;

  // Stage four applies at most two corrections.
  always_comb begin
    if (r3_q >= PRIME_R2) begin
      res4_d = VAL_W'(r3_q - PRIME_R2);
    end else if (r3_q >= PRIME_R) begin
      res4_d = VAL_W'(r3_q - PRIME_R);
    end else begin
      res4_d = VAL_W'(r3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      xlo2_q  <= prod1_q[R_W-1:0];
      t2_q    <= t2_d;
      r3_q    <= r3_d;
      res4_q  <= res4_d;
    end
  end

  // The tag shifts in step with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MODMUL_STAGES; i++) begin
        tag_q[i] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < MODMUL_STAGES; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign prod_o = res4_q;
  assign tag_o  = tag_q[MODMUL_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/bmp_cell.sv =====
// One square-and-multiply cell handling a single exponent bit.
`default_nettype none
module bmp_cell #(
  parameter logic EXP_BIT = 1'b1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic     [bmp_pkg::VAL_W-1:0] acc_i,
  input  wire logic     [bmp_pkg::VAL_W-1:0] sq_i,
  input  wire bmp_pkg::bmp_tag_t             tag_i,
  output logic          [bmp_pkg::VAL_W-1:0] acc_o,
  output logic          [bmp_pkg::VAL_W-1:0] sq_o,
  output bmp_pkg::bmp_tag_t                  tag_o
);
  import bmp_pkg::*;

  // The square always advances and carries the item's tag.
  bmp_modmul u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .a_i    (sq_i),
    .b_i    (sq_i),
    .tag_i  (tag_i),
    .prod_o (sq_o),
    .tag_o  (tag_o)
  );

  if (EXP_BIT) begin : g_mul
    // A set bit multiplies the accumulator by the current square.
    bmp_modmul u_accum (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .a_i    (acc_i),
      .b_i    (sq_i),
      .tag_i  ('0),
      .prod_o (acc_o),
      .tag_o  ()
    );
  end else begin : g_pass
    // A clear bit only delays the accumulator to stay aligned.
    logic [VAL_W-1:0] acc_q [MODMUL_STAGES];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[0] <= acc_i;
        for (int i = 1; i < MODMUL_STAGES; i++) begin
          acc_q[i] <= acc_q[i-1];
        end
      end
    end

    assign acc_o = acc_q[MODMUL_STAGES-1];
  end

endmodule
`default_nettype wire

// ===== hdl/binomial_mod_prime.sv =====
// Throughput: one item per cycle while the output does not stall; the table read, the
// denominator multiplier, the 30 exponent cells (each with a four-stage modular
// multiplier for the square), final multiplier and output register set the latency.
// The pipeline stalls only while its last stage holds an item and the output waits.
// Reset clears all valid flags asynchronously; the factorial tables are constant.
`default_nettype none
module binomial_mod_prime #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [9:0]  top_index_i,
  input  wire logic [9:0]  choose_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [29:0] coefficient_o
);
  import bmp_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = (AW > 10) ? AW : 10;

  logic en;
  logic last_valid;

  // Index handling and special cases.
  logic [9:0]    diff;
  logic          zero_d;
  logic [IW-1:0] n_ext;
  logic [IW-1:0] k_ext;
  logic [IW-1:0] d_ext;
  logic [AW-1:0] addr_n;
  logic [AW-1:0] addr_k;
  logic [AW-1:0] addr_d;

  assign diff   = top_index_i - choose_count_i;
  assign zero_d = (choose_count_i > top_index_i) ||
                  (32'(top_index_i) >= 32'(TABLE_DEPTH));
  assign n_ext  = IW'(top_index_i);
  assign k_ext  = IW'(choose_count_i);
  assign d_ext  = IW'(diff);
  assign addr_n = zero_d ? '0 : n_ext[AW-1:0];
  assign addr_k = zero_d ? '0 : k_ext[AW-1:0];
  assign addr_d = zero_d ? '0 : d_ext[AW-1:0];

  // Three table copies serve the three reads of one item.
  logic [VAL_W-1:0] fact_n;
  logic [VAL_W-1:0] fact_k;
  logic [VAL_W-1:0] fact_d;

  bmp_rom #(.DEPTH(TABLE_DEPTH)) u_rom_n (
    .clk_i (clk_i), .en_i (en), .addr_i (addr_n), .data_o (fact_n)
  );
  bmp_rom #(.DEPTH(TABLE_DEPTH)) u_rom_k (
    .clk_i (clk_i), .en_i (en), .addr_i (addr_k), .data_o (fact_k)
  );
  bmp_rom #(.DEPTH(TABLE_DEPTH)) u_rom_d (
    .clk_i (clk_i), .en_i (en), .addr_i (addr_d), .data_o (fact_d)
  );

  // Flags that travel with the table read stage.
  logic ra_valid_q;
  logic ra_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_valid_q <= 1'b0;
      ra_zero_q  <= 1'b0;
    end else if (en) begin
      ra_valid_q <= in_valid_i;
      ra_zero_q  <= zero_d;
    end
  end

  bmp_tag_t ra_tag;
  assign ra_tag = '{valid: ra_valid_q, zero: ra_zero_q, numer: fact_n};

  // Denominator: k! times (n-k)!.
  logic [VAL_W-1:0] denom;
  bmp_tag_t         den_tag;

  bmp_modmul u_denom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (fact_k),
    .b_i    (fact_d),
    .tag_i  (ra_tag),
    .prod_o (denom),
    .tag_o  (den_tag)
  );

  // Fermat inverse: one cell per exponent bit, least significant bit first.
  logic [VAL_W-1:0] acc_w [EXP_BITS+1];
  logic [VAL_W-1:0] sq_w  [EXP_BITS+1];
  bmp_tag_t         tag_w [EXP_BITS+1];

  assign acc_w[0] = VAL_W'(1);
  assign sq_w[0]  = denom;
  assign tag_w[0] = den_tag;

  for (genvar g = 0; g < EXP_BITS; g++) begin : g_chain
    bmp_cell #(.EXP_BIT(FERMAT_EXP[g])) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .acc_i  (acc_w[g]),
      .sq_i   (sq_w[g]),
      .tag_i  (tag_w[g]),
      .acc_o  (acc_w[g+1]),
      .sq_o   (sq_w[g+1]),
      .tag_o  (tag_w[g+1])
    );
  end

  // Final product: n! times the inverse.
  logic [VAL_W-1:0] final_prod;
  bmp_tag_t         final_tag;

  bmp_modmul u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (tag_w[EXP_BITS].numer),
    .b_i    (acc_w[EXP_BITS]),
    .tag_i  (tag_w[EXP_BITS]),
    .prod_o (final_prod),
    .tag_o  (final_tag)
  );

  assign last_valid = final_tag.valid;

  // The pipeline stalls only when its last item cannot move into the output register.
  assign en         = !out_valid_o || out_ready_i || !last_valid;
  assign in_ready_o = en;

  // Output register.
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && last_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_valid) begin
      out_data_q <= final_tag.zero ? '0 : final_prod;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = out_data_q;

  // An accepted item with k above n is flagged for a zero result.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (choose_count_i > top_index_i)) |=>
      (ra_valid_q && ra_zero_q))
    else $error("item with k above n not flagged");

  // A stall keeps the last stage occupied.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> last_valid)
    else $error("last stage emptied during a stall");

  // The denominator of a live item is never zero.
  a_denom_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (den_tag.valid && !den_tag.zero) |-> (denom != '0))
    else $error("zero denominator reached the inverse chain");

  // Results are always reduced.
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coefficient_o < PRIME_MOD))
    else $error("result not reduced modulo the prime");

endmodule
`default_nettype wire

// ===== tb/bmp_checker.sv =====
// Checker for the binomial coefficient block: watches both channels and compares results.
`default_nettype none
module bmp_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [9:0]  top_index_i,
  input  wire logic [9:0]  choose_count_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [29:0] coefficient_i,
  output int               fail_count_o,
  output int               pending_o
);
  import bmp_pkg::*;

  logic [VAL_W-1:0] fact_table [TABLE_DEPTH];

  // Expected results waiting for their output item, kept in arrival order.
  logic [VAL_W-1:0] coef_fifo [4096];
  logic [11:0]      wr_ptr;
  logic [11:0]      rd_ptr;

  // Product of two residues, reduced modulo the prime.
  function automatic logic [VAL_W-1:0] mul_mod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return VAL_W'(prod % 64'(PRIME_MOD));
  endfunction

  // Inverse by raising to the prime minus two.
  function automatic logic [VAL_W-1:0] inv_mod(logic [VAL_W-1:0] base);
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] sq;
    logic [VAL_W-1:0] ex;
    acc = 1;
    sq = base;
    ex = FERMAT_EXP;
    while (ex != 0) begin
      if (ex[0]) acc = mul_mod(acc, sq);
      sq = mul_mod(sq, sq);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic [VAL_W-1:0] binom_mod(int unsigned n, int unsigned k);
    if (k > n || n >= TABLE_DEPTH) return '0;
    return mul_mod(fact_table[n], inv_mod(mul_mod(fact_table[k], fact_table[n-k])));
  endfunction

  initial begin
    fact_table[0] = 1;
    for (int i = 1; i < TABLE_DEPTH; i++) fact_table[i] = mul_mod(fact_table[i-1], VAL_W'(i));
  end

  assign pending_o = int'(12'(wr_ptr - rd_ptr));

  // Predict on input acceptance, compare on output acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        coef_fifo[wr_ptr] <= binom_mod(top_index_i, choose_count_i);
        wr_ptr <= wr_ptr + 12'd1;
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_ptr == rd_ptr) begin
          $error("coefficient: unexpected item, actual %0d", coefficient_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          rd_ptr <= rd_ptr + 12'd1;
          if (coef_fifo[rd_ptr] !== coefficient_i) begin
            $error("coefficient: expected %0d, actual %0d", coef_fifo[rd_ptr], coefficient_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Top of the testbench: stimulus, receiver stalls and the final verdict.
`default_nettype none
module tb_top;
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [9:0]  top_index_i;
  logic [9:0]  choose_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [29:0] coefficient_o;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          hold_off;

  binomial_mod_prime uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .top_index_i, .choose_count_i,
    .out_valid_o, .out_ready_i, .coefficient_o
  );

  bmp_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .top_index_i, .choose_count_i,
    .out_valid_i(out_valid_o), .out_ready_i, .coefficient_i(coefficient_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one pair and hold it until it is accepted.
  task automatic send_pair(input logic [9:0] n, input logic [9:0] k);
    in_valid_i <= 1'b1;
    top_index_i <= n;
    choose_count_i <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Random pair: mostly k <= n, sometimes anything, sometimes near the top.
  task automatic random_pair();
    logic [9:0] n;
    logic [9:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    n = 10'($urandom);
    if (sel < 6) k = 10'($urandom_range(0, n));
    else if (sel < 8) k = 10'($urandom);
    else begin
      n = 10'($urandom_range(1000, 1023));
      k = 10'($urandom_range(0, 1023));
    end
    send_pair(n, k);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else if (cycle_count % 2000 < 600) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // The long hold-off falls while the sender is still busy, so the pipeline fills.
  initial begin
    hold_off = 1'b0;
    wait (cycle_count == 400);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    top_index_i = '0;
    choose_count_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zeros, extremes, k above n, symmetry.
    send_pair(10'd0, 10'd0);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd1023, 10'd511);
    send_pair(10'd1023, 10'd512);
    send_pair(10'd1023, 10'd1);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd0, 10'd1);
    send_pair(10'd5, 10'd6);
    send_pair(10'd1022, 10'd1023);
    send_pair(10'd1, 10'd1);
    send_pair(10'd2, 10'd1);
    send_pair(10'd682, 10'd341);
    send_pair(10'd341, 10'd682);
    send_pair(10'd20, 10'd10);
    send_pair(10'd1000, 10'd999);
    idle_gap(3);

    // Random bursts with random gaps.
    for (int i = 0; i < 1350;) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && i < 1350; j++, i++) random_pair();
      idle_gap($urandom_range(0, 6));
    end
    in_valid_i <= 1'b0;

    // Drain, then allow the pipeline latency to pass.
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
